[hw/rtl/fully_associative_tlb_core_defines.svh]
// Assertion macros shared by the translation buffer RTL.
`ifndef FULLY_ASSOCIATIVE_TLB_CORE_DEFINES_SVH
`define FULLY_ASSOCIATIVE_TLB_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define FAT_ASSERT_NOW(lbl, clk_s, rst_s, ant, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ant) |-> (cons)) \
		else $error("fat assertion failed");

// next-cycle implication, off during reset
`define FAT_ASSERT_NEXT(lbl, clk_s, rst_s, ant, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ant) |=> (cons)) \
		else $error("fat assertion failed");

`endif

[hw/rtl/fat_pkg.sv]
// Types and constants of the translation buffer.
package fat_pkg;

	localparam int ENTRY_COUNT = 16;
	localparam int PAGE_WIDTH  = 24;
	localparam int FRAME_WIDTH = 16;
	localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CNT_W       = 32;

	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRY_COUNT - 1);

	typedef enum logic [1:0] {
		MODE_LOOKUP     = 2'd0,
		MODE_INSERT     = 2'd1,
		MODE_INVALIDATE = 2'd2
	} mode_t;

	// request as it travels down the cell chain
	typedef struct packed {
		logic                   valid;
		logic [1:0]             mode;
		logic [PAGE_WIDTH-1:0]  page;
		logic [FRAME_WIDTH-1:0] frame;
		logic [IDX_W-1:0]       slot;
		logic                   hit;
		logic [FRAME_WIDTH-1:0] found;
	} token_t;

endpackage

[hw/rtl/fat_ifs.sv]
// Request and response channel interfaces.
interface fat_req_if;
	import fat_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [1:0]             mode;
	logic [PAGE_WIDTH-1:0]  vpn;
	logic [FRAME_WIDTH-1:0] insert_frame;

	modport source (output valid, output mode, output vpn, output insert_frame,
		input ready);
	modport sink (input valid, input mode, input vpn, input insert_frame,
		output ready);
endinterface

interface fat_rsp_if;
	import fat_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [FRAME_WIDTH-1:0] found_frame;
	logic [CNT_W-1:0]       access_count;
	logic [CNT_W-1:0]       hit_count;
	logic [CNT_W-1:0]       miss_count;

	modport source (output valid, output hit, output found_frame, output access_count,
		output hit_count, output miss_count, input ready);
	modport sink (input valid, input hit, input found_frame, input access_count,
		input hit_count, input miss_count, output ready);
endinterface

[hw/rtl/fat_cell.sv]
// One buffer entry plus the chain stage that passes requests to the next entry.
module fat_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic [fat_pkg::IDX_W-1:0] idx,
	input  fat_pkg::token_t         tok_in,
	output fat_pkg::token_t         tok_out
);
	import fat_pkg::*;

	logic                   ent_valid_q;
	logic [PAGE_WIDTH-1:0]  ent_page_q;
	logic [FRAME_WIDTH-1:0] ent_frame_q;
	logic                   tok_valid_q;
	token_t                 tok_q;
	token_t                 tok_nxt;
	logic                   take;
	logic                   wr_ent;
	logic                   match;

	assign take   = adv && tok_in.valid;
	assign wr_ent = take && (tok_in.mode == MODE_INSERT) && (tok_in.slot == idx);
	// earlier cells already claimed the lowest index if they hit
	assign match  = (tok_in.mode == MODE_LOOKUP) && !tok_in.hit && ent_valid_q &&
		(ent_page_q == tok_in.page);

	always_comb begin
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.hit   = 1'b1;
			tok_nxt.found = ent_frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (take) begin
			if (wr_ent)
				ent_valid_q <= 1'b1;
			else if (tok_in.mode == MODE_INVALIDATE)
				ent_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ent) begin
			ent_page_q  <= tok_in.page;
			ent_frame_q <= tok_in.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_valid_q <= 1'b0;
		else if (adv)
			tok_valid_q <= tok_in.valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

[hw/rtl/fat_tail.sv]
// End of the chain: running totals and the response register.
`include "fully_associative_tlb_core_defines.svh"

module fat_tail (
	input  logic            clk,
	input  logic            arst_n,
	input  fat_pkg::token_t tok,
	output logic            adv,
	fat_rsp_if.source       rsp
);
	import fat_pkg::*;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [FRAME_WIDTH-1:0] frame_q;
	logic [CNT_W-1:0]       acc_q;
	logic [CNT_W-1:0]       hits_q;
	logic [CNT_W-1:0]       miss_q;
	logic                   lookup;

	assign adv    = !out_valid_q || rsp.ready;
	assign lookup = adv && tok.valid && (tok.mode == MODE_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			hits_q      <= '0;
			miss_q      <= '0;
		end else begin
			if (adv)
				out_valid_q <= tok.valid;
			if (lookup) begin
				acc_q <= acc_q + 1'b1;
				if (tok.hit)
					hits_q <= hits_q + 1'b1;
				else
					miss_q <= miss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= tok.hit;
			frame_q <= tok.hit ? tok.found : '0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.found_frame  = frame_q;
	assign rsp.access_count = acc_q;
	assign rsp.hit_count    = hits_q;
	assign rsp.miss_count   = miss_q;

	`FAT_ASSERT_NOW(a_totals_add_up, clk, arst_n, 1'b1, acc_q == CNT_W'(hits_q + miss_q))
	`FAT_ASSERT_NEXT(a_totals_hold_on_stall, clk, arst_n, !adv, $stable(acc_q) && $stable(hits_q))
	`FAT_ASSERT_NOW(a_hit_only_on_lookup, clk, arst_n, tok.valid && tok.hit,
		tok.mode == MODE_LOOKUP)

endmodule

[hw/rtl/fully_associative_tlb_core.sv]
// Top level of the fully associative translation buffer with round-robin fill.
//
//  channel  role  carries
//  req      sink  mode, vpn, insert_frame
//  rsp      src   hit, found_frame, access_count, hit_count, miss_count
//
// One request per cycle while the response is not stalled; each request then walks
// one entry cell per cycle, and fat_tail's response register holds its result.
// Reset clears valid bits, replacement pointer and totals; entry contents are not reset.
// A stalled response freezes the whole chain and drops req.ready.
`include "fully_associative_tlb_core_defines.svh"

module fully_associative_tlb_core (
	input  logic   clk,
	input  logic   arst_n,
	fat_req_if.sink   req,
	fat_rsp_if.source rsp
);
	import fat_pkg::*;

	logic             adv;
	logic [IDX_W-1:0] ptr_q;
	logic             ins_xfer;
	token_t           chain [ENTRY_COUNT+1];

	assign req.ready = adv;
	assign ins_xfer  = req.valid && adv && (req.mode == MODE_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ptr_q <= '0;
		else if (ins_xfer)
			ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
	end

	always_comb begin
		chain[0].valid = req.valid;
		chain[0].mode  = req.mode;
		chain[0].page  = req.vpn;
		chain[0].frame = req.insert_frame;
		chain[0].slot  = ptr_q;
		chain[0].hit   = 1'b0;
		chain[0].found = '0;
	end

	for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
		fat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.idx     (IDX_W'(i)),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	fat_tail u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (chain[ENTRY_COUNT]),
		.adv    (adv),
		.rsp    (rsp)
	);

	`FAT_ASSERT_NEXT(a_ptr_advances, clk, arst_n, ins_xfer,
		ptr_q == (($past(ptr_q) == LAST_SLOT) ? '0 : IDX_W'($past(ptr_q) + 1'b1)))
	`FAT_ASSERT_NEXT(a_ptr_holds, clk, arst_n, !ins_xfer, $stable(ptr_q))
	`FAT_ASSERT_NOW(a_ptr_in_range, clk, arst_n, 1'b1, ptr_q <= LAST_SLOT)

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the fully associative translation buffer core.
`timescale 1ns / 1ps

module tb_top;
	import fat_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int LATENCY      = ENTRY_COUNT;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 750;
	localparam int POOL_SIZE    = 24;

	typedef struct packed {
		logic [1:0]             mode;
		logic [PAGE_WIDTH-1:0]  page;
		logic [FRAME_WIDTH-1:0] frame;
	} xlate_req_t;

	typedef struct packed {
		logic                   hit;
		logic [FRAME_WIDTH-1:0] frame;
		logic [CNT_W-1:0]       lookups;
		logic [CNT_W-1:0]       hits;
		logic [CNT_W-1:0]       misses;
	} xlate_rsp_t;

	typedef struct packed {
		xlate_req_t req;
		logic       typed;
		xlate_rsp_t rsp;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 22;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty after reset: miss
		'{'{MODE_LOOKUP, 24'h000000, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 32'd1, 32'd0, 32'd1}},
		'{'{MODE_INSERT, 24'hFFFFFF, 16'hFFFF}, 1'b1, '{1'b0, 16'h0000, 32'd1, 32'd0, 32'd1}},
		'{'{MODE_LOOKUP, 24'hFFFFFF, 16'h0000}, 1'b1, '{1'b1, 16'hFFFF, 32'd2, 32'd1, 32'd1}},
		'{'{MODE_INSERT, 24'h000000, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 32'd2, 32'd1, 32'd1}},
		// frame field is ignored on lookup
		'{'{MODE_LOOKUP, 24'h000000, 16'hFFFF}, 1'b1, '{1'b1, 16'h0000, 32'd3, 32'd2, 32'd1}},
		// duplicate page: lower slot wins
		'{'{MODE_INSERT, 24'h123456, 16'hAAAA}, 1'b0, '0},
		'{'{MODE_INSERT, 24'h123456, 16'h5555}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'h123456, 16'h0000}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'h123457, 16'h0000}, 1'b0, '0},
		'{'{MODE_UNUSED, 24'hABCDEF, 16'h1234}, 1'b0, '0},
		'{'{MODE_INSERT, 24'hAAAAAA, 16'h5555}, 1'b0, '0},
		'{'{MODE_INSERT, 24'h555555, 16'hAAAA}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'h555555, 16'h0000}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'hAAAAAA, 16'h0000}, 1'b0, '0},
		'{'{MODE_INVALIDATE, 24'h000000, 16'h0000}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'hFFFFFF, 16'h0000}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'h000000, 16'h0000}, 1'b0, '0},
		// pointer survives the flush
		'{'{MODE_INSERT, 24'h800001, 16'h8001}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'h800001, 16'h0000}, 1'b0, '0},
		'{'{MODE_INVALIDATE, 24'hFFFFFF, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_UNUSED, 24'hFFFFFF, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_LOOKUP, 24'h800001, 16'h0000}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	fat_req_if req_ch ();
	fat_rsp_if rsp_ch ();

	fully_associative_tlb_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow translation state
	logic                   entry_live [ENTRY_COUNT];
	logic [PAGE_WIDTH-1:0]  entry_vpn  [ENTRY_COUNT];
	logic [FRAME_WIDTH-1:0] entry_pfn  [ENTRY_COUNT];
	logic [IDX_W-1:0]       fill_slot;
	logic [CNT_W-1:0]       lookup_cnt;
	logic [CNT_W-1:0]       hit_cnt;
	logic [CNT_W-1:0]       miss_cnt;

	xlate_rsp_t            pending_translations [$];
	logic [PAGE_WIDTH-1:0] known_pages [POOL_SIZE];

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int mismatch_cnt    = 0;
	int item_cnt        = 0;
	int result_cnt      = 0;
	int insert_cnt      = 0;
	int flush_cnt       = 0;
	int quiet_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic xlate_rsp_t translate(input xlate_req_t r);
		xlate_rsp_t res;
		res = '0;
		case (r.mode)
		MODE_LOOKUP: begin
			lookup_cnt++;
			// scan downward so the lowest matching slot is the one kept
			for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
				if (entry_live[i] && entry_vpn[i] == r.page) begin
					res.hit   = 1'b1;
					res.frame = entry_pfn[i];
				end
			end
			if (res.hit)
				hit_cnt++;
			else
				miss_cnt++;
		end
		MODE_INSERT: begin
			entry_live[fill_slot] = 1'b1;
			entry_vpn[fill_slot]  = r.page;
			entry_pfn[fill_slot]  = r.frame;
			fill_slot = (fill_slot == LAST_SLOT) ? '0 : fill_slot + 1'b1;
		end
		MODE_INVALIDATE: begin
			for (int i = 0; i < ENTRY_COUNT; i++)
				entry_live[i] = 1'b0;
		end
		default: ;
		endcase
		res.lookups = lookup_cnt;
		res.hits    = hit_cnt;
		res.misses  = miss_cnt;
		return res;
	endfunction

	function automatic xlate_req_t random_request();
		xlate_req_t r;
		int roll;
		roll    = $urandom_range(99);
		r.page  = known_pages[$urandom_range(POOL_SIZE - 1)];
		r.frame = FRAME_WIDTH'($urandom);
		if (roll < 48) begin
			r.mode = MODE_LOOKUP;
		end else if (roll < 58) begin
			r.mode = MODE_LOOKUP;
			r.page = PAGE_WIDTH'($urandom);
		end else if (roll < 88) begin
			r.mode = MODE_INSERT;
		end else if (roll < 96) begin
			r.mode = MODE_INSERT;
			r.page = PAGE_WIDTH'($urandom);
		end else if (roll < 98) begin
			r.mode = MODE_INVALIDATE;
		end else begin
			r.mode = MODE_UNUSED;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [CNT_W-1:0] got,
		input logic [CNT_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
				result_cnt, name, got, want));
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic drive_item(input xlate_req_t r, input logic typed, input xlate_rsp_t typed_rsp);
		xlate_rsp_t predicted;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.mode         = r.mode;
		req_ch.vpn          = r.page;
		req_ch.insert_frame = r.frame;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = translate(r);
		pending_translations.push_back(typed ? typed_rsp : predicted);
		item_cnt++;
		if (r.mode == MODE_INSERT)
			insert_cnt++;
		if (r.mode == MODE_INVALIDATE)
			flush_cnt++;
		@(negedge clk);
	endtask

	// response side back-pressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		xlate_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			result_cnt++;
			if (pending_translations.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending", result_cnt));
			end else begin
				want = pending_translations.pop_front();
				compare_field("hit", CNT_W'(rsp_ch.hit), CNT_W'(want.hit));
				compare_field("found_frame", CNT_W'(rsp_ch.found_frame), CNT_W'(want.frame));
				compare_field("access_count", rsp_ch.access_count, want.lookups);
				compare_field("hit_count", rsp_ch.hit_count, want.hits);
				compare_field("miss_count", rsp_ch.miss_count, want.misses);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results pending",
					quiet_cycles, pending_translations.size());
				$display("** fully_associative_tlb_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		xlate_req_t r;
		int issued;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_LOOKUP;
		req_ch.vpn          = '0;
		req_ch.insert_frame = '0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			entry_live[i] = 1'b0;
			entry_vpn[i]  = '0;
			entry_pfn[i]  = '0;
		end
		fill_slot  = '0;
		lookup_cnt = '0;
		hit_cnt    = '0;
		miss_cnt   = '0;

		// half random pages, half one-bit neighbors of earlier ones
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i < POOL_SIZE / 2)
				known_pages[i] = PAGE_WIDTH'($urandom);
			else
				known_pages[i] = known_pages[i - POOL_SIZE / 2]
					^ (PAGE_WIDTH'(1) << $urandom_range(PAGE_WIDTH - 1));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			drive_item(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].rsp);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				sender_idle_pct = 0;
				stall_pct       = 0;
			end
			1: begin
				sender_idle_pct = 50;
				stall_pct       = 0;
			end
			2: begin
				sender_idle_pct = 0;
				stall_pct       = 50;
			end
			default: begin
				sender_idle_pct = 6;
				stall_pct       = 6;
			end
			endcase
			issued = 0;
			while (issued < RANDOM_ITEMS / 4) begin
				r = random_request();
				drive_item(r, 1'b0, '0);
				if (r.mode != MODE_UNUSED)
					issued++;
			end
		end
		req_ch.valid = 1'b0;

		while (pending_translations.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display("ran %0d requests (%0d inserts, %0d flushes), checked %0d responses",
			item_cnt, insert_cnt, flush_cnt, result_cnt);
		$display("lookups %0d: %0d hits, %0d misses; %0d mismatches",
			lookup_cnt, hit_cnt, miss_cnt, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("** fully_associative_tlb_core: PASSED **");
		else
			$display("** fully_associative_tlb_core: FAILED **");
		$finish;
	end

endmodule
